// File: rtl/uhrd_pkg.sv
// Package: shared types and constants of the UTF-16 high-byte RLE decoder.
`default_nettype none

package uhrd_pkg;

    // Decoded bytes per code unit.
    localparam logic [16:0] UNIT_BYTES = 17'd2;

    // Register reset value.
    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    // Result kinds.
    localparam logic [1:0] KIND_UNIT = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_OVF  = 2'd2;

    // Result queue geometry.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_CW    = 3;

    // Decoder phase, one-hot.
    typedef enum logic [2:0] {
        PH_COUNT = 3'b001,
        PH_HIGH  = 3'b010,
        PH_LIT   = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] code_unit;
        logic [15:0] bytes_total;
        logic        end_mark;
    } t_result;

    // Up to two results made by one input item; v1 implies v0.
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

`default_nettype wire

// File: rtl/uhrd_in_if.sv
// Interface: input byte channel.
`default_nettype none

interface uhrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/uhrd_out_if.sv
// Interface: result channel.
`default_nettype none

interface uhrd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] code_unit;
    logic [15:0] bytes_total;
    logic        end_mark;

    modport source (output valid, output kind, output code_unit, output bytes_total,
                    output end_mark, input ready);
    modport sink   (input valid, input kind, input code_unit, input bytes_total,
                    input end_mark, output ready);
endinterface

`default_nettype wire

// File: rtl/utf16_high_byte_rle_decoder.sv
// Top level: UTF-16 high-byte run-length decoder.
// Results are registered in the result queue as their input item is accepted.
// Throughput: one input item per cycle while the queue has room; a final byte
//   that ends a unit or an overflow makes two results, which leave one by one.
// Rate is set by the one-result-per-cycle output port and the 4-entry queue.
// Reset (synchronous, active low): phase to count byte, counters and overflow
//   flag cleared, capacity register to 65535, result queue emptied.
`default_nettype none

module utf16_high_byte_rle_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    uhrd_in_if.sink          i_in,
    uhrd_out_if.source       o_out,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data
);

    uhrd_pkg::t_push   push;
    uhrd_pkg::t_result head;
    logic              room;
    logic              take;

    // Ready depends only on queue room, so an item can enter every cycle
    // while earlier results drain.
    assign i_in.ready = room;
    assign take       = i_in.valid && room;

    // Segment decoding: count byte, shared high byte, then literal low bytes.
    uhrd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_data_byte   (i_in.data_byte),
        .i_final_byte  (i_in.final_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (push)
    );

    // Results queue; decouples decode from a stalled sink.
    uhrd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_head  (head),
        .o_room  (room)
    );

    assign o_out.kind        = head.kind;
    assign o_out.code_unit   = head.code_unit;
    assign o_out.bytes_total = head.bytes_total;
    assign o_out.end_mark    = head.end_mark;

endmodule

`default_nettype wire

// File: rtl/uhrd_core.sv
// Decode core: segment state, capacity register and result generation.
`default_nettype none

module uhrd_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_final_byte,
    input  wire logic            i_cfg_wr_en,
    input  wire logic [15:0]     i_cfg_wr_data,
    output uhrd_pkg::t_push      o_push
);

    uhrd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_remaining, n_remaining;
    logic [7:0]       r_high, n_high;
    logic [15:0]      r_written, n_written;
    logic             r_overflowed, n_overflowed;
    logic [15:0]      r_capacity;
    logic             fits;
    uhrd_pkg::t_push  push;

    // 17-bit sum so a full count does not wrap.
    assign fits = ({1'b0, r_written} + uhrd_pkg::UNIT_BYTES) <= {1'b0, r_capacity};

    always_comb begin
        n_phase      = r_phase;
        n_remaining  = r_remaining;
        n_high       = r_high;
        n_written    = r_written;
        n_overflowed = r_overflowed;
        push         = '0;
        if (i_take) begin
            if (!r_overflowed) begin
                unique case (r_phase)
                    uhrd_pkg::PH_HIGH: begin
                        n_high  = i_data_byte;
                        n_phase = (r_remaining != 8'd0) ? uhrd_pkg::PH_LIT
                                                        : uhrd_pkg::PH_COUNT;
                    end
                    uhrd_pkg::PH_LIT: begin
                        if (!fits) begin
                            n_overflowed        = 1'b1;
                            push.v0             = 1'b1;
                            push.r0.kind        = uhrd_pkg::KIND_OVF;
                            push.r0.bytes_total = r_written;
                        end else begin
                            n_written           = r_written + 16'd2;
                            push.v0             = 1'b1;
                            push.r0.kind        = uhrd_pkg::KIND_UNIT;
                            push.r0.code_unit   = {r_high, i_data_byte};
                            push.r0.bytes_total = n_written;
                            n_remaining         = r_remaining - 8'd1;
                            if (r_remaining == 8'd1) begin
                                n_phase = uhrd_pkg::PH_COUNT;
                            end
                        end
                    end
                    default: begin
                        n_remaining = i_data_byte;
                        n_phase     = uhrd_pkg::PH_HIGH;
                    end
                endcase
            end
            if (i_final_byte) begin
                // End result follows any unit or overflow result.
                if (push.v0) begin
                    push.v1             = 1'b1;
                    push.r1.kind        = uhrd_pkg::KIND_END;
                    push.r1.bytes_total = n_written;
                    push.r1.end_mark    = 1'b1;
                end else begin
                    push.v0             = 1'b1;
                    push.r0.kind        = uhrd_pkg::KIND_END;
                    push.r0.bytes_total = n_written;
                    push.r0.end_mark    = 1'b1;
                end
                n_phase      = uhrd_pkg::PH_COUNT;
                n_remaining  = 8'd0;
                n_high       = 8'd0;
                n_written    = 16'd0;
                n_overflowed = 1'b0;
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= uhrd_pkg::PH_COUNT;
            r_remaining  <= 8'd0;
            r_high       <= 8'd0;
            r_written    <= 16'd0;
            r_overflowed <= 1'b0;
            r_capacity   <= uhrd_pkg::CAPACITY_RESET;
        end else begin
            r_phase      <= n_phase;
            r_remaining  <= n_remaining;
            r_high       <= n_high;
            r_written    <= n_written;
            r_overflowed <= n_overflowed;
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/uhrd_outq.sv
// Result queue: takes up to two results a cycle, gives one.
`default_nettype none

module uhrd_outq (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire uhrd_pkg::t_push        i_push,
    input  wire logic                   i_pop,
    output logic                        o_valid,
    output uhrd_pkg::t_result           o_head,
    output logic                        o_room
);

    uhrd_pkg::t_result                   r_mem [uhrd_pkg::QUEUE_DEPTH];
    logic [uhrd_pkg::QUEUE_AW-1:0]       r_wr_ptr, n_wr_ptr;
    logic [uhrd_pkg::QUEUE_AW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [uhrd_pkg::QUEUE_CW-1:0]       r_count, n_count;
    logic [uhrd_pkg::QUEUE_CW-1:0]       push_n;
    logic                                pop_ok;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    // Room for the worst case of two results.
    assign o_room  = (r_count <= uhrd_pkg::QUEUE_CW'(uhrd_pkg::QUEUE_DEPTH - 2));
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        push_n   = uhrd_pkg::QUEUE_CW'(i_push.v0) + uhrd_pkg::QUEUE_CW'(i_push.v1);
        n_wr_ptr = r_wr_ptr + push_n[uhrd_pkg::QUEUE_AW-1:0];
        n_rd_ptr = r_rd_ptr + uhrd_pkg::QUEUE_AW'(pop_ok);
        n_count  = r_count + push_n - uhrd_pkg::QUEUE_CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[r_wr_ptr + uhrd_pkg::QUEUE_AW'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire
